@@ rtl/core/atci_pkg.sv @@
package atci_pkg;

  typedef enum logic [1:0] {
    FormChs   = 2'd0,
    FormLba28 = 2'd1,
    FormLba48 = 2'd2
  } form_e;

  typedef enum logic [2:0] {
    RegPriCmdBase = 3'd0,
    RegPriCtrl    = 3'd1,
    RegSecCmdBase = 3'd2,
    RegSecCtrl    = 3'd3,
    RegDriveMap   = 3'd4,
    RegLbaMask    = 3'd5
  } reg_idx_e;

  // task-file register offsets from the command block base
  localparam logic [15:0] OffSectorCount = 16'd2;
  localparam logic [15:0] OffLbaLow      = 16'd3;
  localparam logic [15:0] OffLbaMid      = 16'd4;
  localparam logic [15:0] OffLbaHigh     = 16'd5;
  localparam logic [15:0] OffDevice      = 16'd6;
  localparam logic [15:0] OffCommand     = 16'd7;

  localparam logic [7:0] CtrlNien     = 8'h02;
  localparam logic [7:0] CtrlHob      = 8'h80;
  localparam logic [7:0] DevSelChs    = 8'hA0;
  localparam logic [7:0] DevSelLba    = 8'hE0;
  localparam logic [7:0] CmdRead      = 8'h20;
  localparam logic [7:0] CmdReadExt   = 8'h24;
  localparam logic [7:0] CmdWrite     = 8'h30;
  localparam logic [7:0] CmdWriteExt  = 8'h34;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [15:0] pri_cmd_base;
    logic [15:0] pri_ctrl;
    logic [15:0] sec_cmd_base;
    logic [15:0] sec_ctrl;
    logic [7:0]  drive_map;
    logic [3:0]  lba_mask;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  disk_index;
    logic [31:0] block_address;
    logic [7:0]  sector_count;
  } req_t;

  // fully classified command, ready for the sequencer
  typedef struct packed {
    form_e       form;
    logic [15:0] ctrl;
    logic [15:0] base;
    logic [7:0]  devsel;
    logic [7:0]  count;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  cmd;
  } desc_t;

endpackage

@@ rtl/core/atci_front.sv @@
module atci_front #(
  parameter int HEADS_PER_CYLINDER = 16,
  parameter int SECTORS_PER_TRACK  = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  atci_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  atci_pkg::req_t   req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output atci_pkg::desc_t  desc_o
);

  // floor((2^32-1)/d) underestimates n/d by less than one for n < 2^28
  localparam logic [63:0] RecipSWide = 64'hFFFF_FFFF / 64'(SECTORS_PER_TRACK);
  localparam logic [63:0] RecipHWide = 64'hFFFF_FFFF / 64'(HEADS_PER_CYLINDER);
  localparam logic [31:0] RecipS = RecipSWide[31:0];
  localparam logic [31:0] RecipH = RecipHWide[31:0];
  localparam logic [8:0]  SptW   = 9'(SECTORS_PER_TRACK);
  localparam logic [4:0]  HpcW   = 5'(HEADS_PER_CYLINDER);

  logic adv;

  logic           v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  atci_pkg::req_t r1_q, r2_q, r3_q, r4_q, r5_q, r6_q;

  logic [59:0] p1_d, p1_q;
  logic [27:0] qe1_d, qe1_q, prod2_d, prod2_q;
  logic [8:0]  rem1;
  logic [27:0] track_d, track3_q, track4_q, track5_q;
  logic [7:0]  sr_d, sr3_q, sr4_q, sr5_q, sr6_q;
  logic [59:0] p4_d, p4_q;
  logic [27:0] qe2_d, qe2_q, prod5_d, prod5_q;
  logic [4:0]  rem2;
  logic [27:0] cyl_d;
  logic [4:0]  head_d;
  logic [15:0] cyl_q;
  logic [3:0]  head_q;

  // hold the whole pipe while the finished item cannot leave
  assign adv        = !(v6_q && !out_ready_i);
  assign in_ready_o = adv;

  assign p1_d    = req_i.block_address[27:0] * RecipS;
  assign qe1_d   = p1_q[59:32];
  assign prod2_d = 28'(qe1_d * 28'(SECTORS_PER_TRACK));

  always_comb begin
    rem1 = 9'(r2_q.block_address[27:0] - prod2_q);
    if (rem1 >= SptW) begin
      track_d = qe1_q + 28'd1;
      sr_d    = 8'(rem1 - SptW);
    end else begin
      track_d = qe1_q;
      sr_d    = rem1[7:0];
    end
  end

  assign p4_d    = track3_q * RecipH;
  assign qe2_d   = p4_q[59:32];
  assign prod5_d = 28'(qe2_d * 28'(HEADS_PER_CYLINDER));

  always_comb begin
    rem2 = 5'(track5_q - prod5_q);
    if (rem2 >= HpcW) begin
      cyl_d  = qe2_q + 28'd1;
      head_d = rem2 - HpcW;
    end else begin
      cyl_d  = qe2_q;
      head_d = rem2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q     <= req_i;
      p1_q     <= p1_d;
      r2_q     <= r1_q;
      qe1_q    <= qe1_d;
      prod2_q  <= prod2_d;
      r3_q     <= r2_q;
      track3_q <= track_d;
      sr3_q    <= sr_d;
      r4_q     <= r3_q;
      track4_q <= track3_q;
      sr4_q    <= sr3_q;
      p4_q     <= p4_d;
      r5_q     <= r4_q;
      track5_q <= track4_q;
      sr5_q    <= sr4_q;
      qe2_q    <= qe2_d;
      prod5_q  <= prod5_d;
      r6_q     <= r5_q;
      sr6_q    <= sr5_q;
      cyl_q    <= cyl_d[15:0];
      head_q   <= head_d[3:0];
    end
  end

  // classify the finished item against the current configuration
  logic       chan, slave, lba_ok;
  logic [3:0] dev_low;
  logic [7:0] sect;

  always_comb begin
    chan   = cfg_i.drive_map[{r6_q.disk_index, 1'b1}];
    slave  = cfg_i.drive_map[{r6_q.disk_index, 1'b0}];
    lba_ok = cfg_i.lba_mask[r6_q.disk_index];
    sect   = sr6_q + 8'd1;

    desc_o.ctrl  = chan ? cfg_i.sec_ctrl : cfg_i.pri_ctrl;
    desc_o.base  = chan ? cfg_i.sec_cmd_base : cfg_i.pri_cmd_base;
    desc_o.count = r6_q.sector_count;
    desc_o.b3    = r6_q.block_address[31:24];

    if (r6_q.block_address[31:28] != 4'd0) begin
      desc_o.form = atci_pkg::FormLba48;
      dev_low     = 4'd0;
    end else if (lba_ok) begin
      desc_o.form = atci_pkg::FormLba28;
      dev_low     = r6_q.block_address[27:24];
    end else begin
      desc_o.form = atci_pkg::FormChs;
      dev_low     = head_q;
    end

    if (desc_o.form == atci_pkg::FormChs) begin
      desc_o.b0     = sect;
      desc_o.b1     = cyl_q[7:0];
      desc_o.b2     = cyl_q[15:8];
      desc_o.devsel = atci_pkg::DevSelChs | {3'b000, slave, dev_low};
    end else begin
      desc_o.b0     = r6_q.block_address[7:0];
      desc_o.b1     = r6_q.block_address[15:8];
      desc_o.b2     = r6_q.block_address[23:16];
      desc_o.devsel = atci_pkg::DevSelLba | {3'b000, slave, dev_low};
    end

    if (desc_o.form == atci_pkg::FormLba48) begin
      desc_o.cmd = r6_q.mode ? atci_pkg::CmdWriteExt : atci_pkg::CmdReadExt;
    end else begin
      desc_o.cmd = r6_q.mode ? atci_pkg::CmdWrite : atci_pkg::CmdRead;
    end
  end

  assign out_valid_o = v6_q;

endmodule

@@ rtl/core/atci_queue.sv @@
module atci_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  atci_pkg::desc_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output atci_pkg::desc_t  head_o
);

  localparam int unsigned CntW = $clog2(atci_pkg::QueueDepth + 1);

  atci_pkg::desc_t                    mem_q [atci_pkg::QueueDepth];
  logic [atci_pkg::QueuePtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]                    cnt_q;
  logic                               do_push, do_pop;

  assign full_o  = cnt_q == CntW'(atci_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == atci_pkg::QueuePtrW'(atci_pkg::QueueDepth - 1)) ? '0
                                                                             : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == atci_pkg::QueuePtrW'(atci_pkg::QueueDepth - 1)) ? '0
                                                                             : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/atci_back.sv @@
module atci_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             desc_valid_i,
  input  atci_pkg::desc_t  desc_i,
  output logic             desc_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [15:0]      port_address_o,
  output logic [7:0]       write_value_o,
  output logic [1:0]       address_form_o,
  output logic             last_o
);

  typedef enum logic [4:0] {
    StCtrlInit, StDevSel,
    StHob0Set, StCountHi, StHob0Clr,
    StHob1Set, StLba3,    StHob1Clr,
    StHob2Set, StLba4,    StHob2Clr,
    StHob3Set, StLba5,    StHob3Clr,
    StCount, StLba0, StLba1, StLba2, StCommand
  } step_e;

  step_e       step_q, step_d;
  logic        out_valid_q;
  logic [15:0] port_q, port_d;
  logic [7:0]  value_q, value_d;
  logic [1:0]  form_q;
  logic        last_q, last_d;
  logic        load;
  logic [7:0]  hob_set;

  assign load       = desc_valid_i && (!out_valid_q || pop_i);
  assign desc_pop_o = load && (step_q == StCommand);
  assign hob_set    = atci_pkg::CtrlHob | atci_pkg::CtrlNien;

  always_comb begin
    if (step_q == StCommand) begin
      step_d = StCtrlInit;
    end else if (step_q == StDevSel && desc_i.form != atci_pkg::FormLba48) begin
      step_d = StCount;
    end else begin
      step_d = step_e'(5'(step_q + 5'd1));
    end
  end

  always_comb begin
    last_d = 1'b0;
    unique case (step_q)
      StCtrlInit: begin
        port_d  = desc_i.ctrl;
        value_d = atci_pkg::CtrlNien;
      end
      StDevSel: begin
        port_d  = desc_i.base + atci_pkg::OffDevice;
        value_d = desc_i.devsel;
      end
      StHob0Set, StHob1Set, StHob2Set, StHob3Set: begin
        port_d  = desc_i.ctrl;
        value_d = hob_set;
      end
      StHob0Clr, StHob1Clr, StHob2Clr, StHob3Clr: begin
        port_d  = desc_i.ctrl;
        value_d = atci_pkg::CtrlNien;
      end
      StCountHi: begin
        port_d  = desc_i.base + atci_pkg::OffSectorCount;
        value_d = 8'd0;
      end
      StLba3: begin
        port_d  = desc_i.base + atci_pkg::OffLbaLow;
        value_d = desc_i.b3;
      end
      StLba4: begin
        port_d  = desc_i.base + atci_pkg::OffLbaMid;
        value_d = 8'd0;
      end
      StLba5: begin
        port_d  = desc_i.base + atci_pkg::OffLbaHigh;
        value_d = 8'd0;
      end
      StCount: begin
        port_d  = desc_i.base + atci_pkg::OffSectorCount;
        value_d = desc_i.count;
      end
      StLba0: begin
        port_d  = desc_i.base + atci_pkg::OffLbaLow;
        value_d = desc_i.b0;
      end
      StLba1: begin
        port_d  = desc_i.base + atci_pkg::OffLbaMid;
        value_d = desc_i.b1;
      end
      StLba2: begin
        port_d  = desc_i.base + atci_pkg::OffLbaHigh;
        value_d = desc_i.b2;
      end
      StCommand: begin
        port_d  = desc_i.base + atci_pkg::OffCommand;
        value_d = desc_i.cmd;
        last_d  = 1'b1;
      end
      default: begin
        port_d  = desc_i.ctrl;
        value_d = atci_pkg::CtrlNien;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StCtrlInit;
      out_valid_q <= 1'b0;
      port_q      <= '0;
      value_q     <= '0;
      form_q      <= '0;
      last_q      <= 1'b0;
    end else if (load) begin
      // advance one beat into the output register
      step_q      <= step_d;
      out_valid_q <= 1'b1;
      port_q      <= port_d;
      value_q     <= value_d;
      form_q      <= desc_i.form;
      last_q      <= last_d;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o        = !out_valid_q;
  assign port_address_o = port_q;
  assign write_value_o  = value_q;
  assign address_form_o = form_q;
  assign last_o         = last_q;

endmodule

@@ rtl/core/ata_taskfile_command_issuer.sv @@
// ATA PIO task-file command issuer. Each request (push side) becomes a run of
// I/O register writes on the result side, one beat per write: 7 beats for CHS
// and LBA28, 19 for LBA48, the last beat flagged on the command register. The
// back sequencer emits one beat per cycle while a command is queued and the
// result side pops. Requests enter at one per cycle, unless the pipe is held,
// into a 6-stage classifier (CHS division by reciprocal multiplication) and
// wait in a 4-entry command queue; push sees full only once the classifier
// and queue are backed up. Requests reach the output via the classifier
// stages, the queue and the output register. Configuration registers sit at
// byte address 4*i and must only be written while the block is idle.
module ata_taskfile_command_issuer #(
  parameter int HEADS_PER_CYLINDER = 16,
  parameter int SECTORS_PER_TRACK  = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [1:0]  disk_index_i,
  input  logic [31:0] block_address_i,
  input  logic [7:0]  sector_count_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] port_address_o,
  output logic [7:0]  write_value_o,
  output logic [1:0]  address_form_o,
  output logic        last_o
);

  atci_pkg::cfg_t     cfg_q;
  atci_pkg::reg_idx_e reg_idx;
  atci_pkg::req_t     req;
  atci_pkg::desc_t    front_desc, head_desc;
  logic               front_valid, q_full, q_empty, q_pop, front_ready;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = atci_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pri_cmd_base <= 16'h01F0;
      cfg_q.pri_ctrl     <= 16'h03F6;
      cfg_q.sec_cmd_base <= 16'h0170;
      cfg_q.sec_ctrl     <= 16'h0376;
      cfg_q.drive_map    <= 8'hE4;
      cfg_q.lba_mask     <= 4'hF;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        atci_pkg::RegPriCmdBase: cfg_q.pri_cmd_base <= pwdata[15:0];
        atci_pkg::RegPriCtrl:    cfg_q.pri_ctrl     <= pwdata[15:0];
        atci_pkg::RegSecCmdBase: cfg_q.sec_cmd_base <= pwdata[15:0];
        atci_pkg::RegSecCtrl:    cfg_q.sec_ctrl     <= pwdata[15:0];
        atci_pkg::RegDriveMap:   cfg_q.drive_map    <= pwdata[7:0];
        atci_pkg::RegLbaMask:    cfg_q.lba_mask     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      atci_pkg::RegPriCmdBase: prdata = {16'd0, cfg_q.pri_cmd_base};
      atci_pkg::RegPriCtrl:    prdata = {16'd0, cfg_q.pri_ctrl};
      atci_pkg::RegSecCmdBase: prdata = {16'd0, cfg_q.sec_cmd_base};
      atci_pkg::RegSecCtrl:    prdata = {16'd0, cfg_q.sec_ctrl};
      atci_pkg::RegDriveMap:   prdata = {24'd0, cfg_q.drive_map};
      atci_pkg::RegLbaMask:    prdata = {28'd0, cfg_q.lba_mask};
      default:                 prdata = 32'd0;
    endcase
  end

  assign req.mode          = mode_i;
  assign req.disk_index    = disk_index_i;
  assign req.block_address = block_address_i;
  assign req.sector_count  = sector_count_i;
  assign full              = !front_ready;

  atci_front #(
    .HEADS_PER_CYLINDER (HEADS_PER_CYLINDER),
    .SECTORS_PER_TRACK  (SECTORS_PER_TRACK)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .req_i       (req),
    .out_valid_o (front_valid),
    .out_ready_i (!q_full),
    .desc_o      (front_desc)
  );

  atci_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_desc)
  );

  atci_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_valid_i   (!q_empty),
    .desc_i         (head_desc),
    .desc_pop_o     (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .port_address_o (port_address_o),
    .write_value_o  (write_value_o),
    .address_form_o (address_form_o),
    .last_o         (last_o)
  );

endmodule
